// ===== hw/rtl/bounded_deque_with_search_top_macros.svh =====
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define BDWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdws assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define BDWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdws assertion failed");

`endif

// ===== hw/rtl/bdws_pkg.sv =====
package bdws_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } sts_code_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic srch_step;
    logic srch_out;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_search;
    logic srch_end;
  } dp_sts_t;

  // Ring index arithmetic: both operands are below DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

endpackage

// ===== hw/rtl/bdws_if.sv =====
interface bdws_in_if;
  logic                              valid;
  logic                              ready;
  logic        [bdws_pkg::CMD_W-1:0] cmd;
  logic signed [bdws_pkg::VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdws_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdws_pkg::STS_W-1:0] status;
  logic [bdws_pkg::POS_W-1:0] position;
  logic [bdws_pkg::CNT_W-1:0] count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink   (input valid, input status, input position, input count, output ready);
endinterface

// ===== hw/rtl/bounded_deque_with_search_top.sv =====
// Bounded double-ended queue of signed 32-bit values with a linear search.
// Input channel in_ch carries one command per transaction (push front, push
// back, pop front, pop back, search, clear) and a value or search key.
// Output channel out_ch returns exactly one result per command: a status,
// the position of the first match for a successful search, and the count.
// The block works on one command at a time. The result of a push, pop, clear
// or unused command is loaded from the execute state; that of a search once
// the scan hits or runs out of entries, paced by the single read port of the
// entry memory, which yields one stored entry per cycle to the comparator.
// The next command is taken the cycle after the result is loaded, so no new
// command is accepted before the previous one has loaded its result.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the entry memory itself is not cleared. If the receiver stalls,
// the result is held in the output register and one further command is
// still accepted; its result waits until the held one has been taken.
module bounded_deque_with_search_top (
  input  logic               clk,
  input  logic               rst_n,
  bdws_in_if.sink            in_ch,
  bdws_out_if.source         out_ch
);

  bdws_pkg::ctl_cmd_t ctl_cmd;
  bdws_pkg::dp_sts_t  dp_sts;

  bdws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (ctl_cmd),
    .sts       (dp_sts)
  );

  bdws_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (ctl_cmd),
    .sts          (dp_sts),
    .in_cmd       (in_ch.cmd),
    .in_value     (in_ch.value),
    .out_status   (out_ch.status),
    .out_position (out_ch.position),
    .out_count    (out_ch.count)
  );

endmodule

// ===== hw/rtl/bdws_dp.sv =====
`include "bounded_deque_with_search_top_macros.svh"

module bdws_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdws_pkg::ctl_cmd_t                cmd,
  output bdws_pkg::dp_sts_t                 sts,
  input  logic        [bdws_pkg::CMD_W-1:0] in_cmd,
  input  logic signed [bdws_pkg::VAL_W-1:0] in_value,
  output logic        [bdws_pkg::STS_W-1:0] out_status,
  output logic        [bdws_pkg::POS_W-1:0] out_position,
  output logic        [bdws_pkg::CNT_W-1:0] out_count
);

  logic [bdws_pkg::VAL_W-1:0] mem [bdws_pkg::DEPTH];

  logic [bdws_pkg::CMD_W-1:0] op_r;
  logic [bdws_pkg::VAL_W-1:0] key_r;
  logic [bdws_pkg::AW-1:0]    head_r, head_nxt;
  logic [bdws_pkg::CW-1:0]    count_r, count_nxt;
  logic [bdws_pkg::CW-1:0]    idx_r;
  logic                       rd_vld_r;
  logic [bdws_pkg::AW-1:0]    rd_pos_r;
  logic [bdws_pkg::VAL_W-1:0] rd_data_r;
  logic [bdws_pkg::STS_W-1:0] status_r, status_nxt;
  logic [bdws_pkg::POS_W-1:0] pos_r;
  logic [bdws_pkg::CNT_W-1:0] cnt_r;

  logic                       full, empty, hit, step_go, rd_issue;
  logic                       wr_en;
  logic [bdws_pkg::AW-1:0]    wr_addr, rd_addr;

  assign full     = (count_r == bdws_pkg::DEPTH_C);
  assign empty    = (count_r == '0);
  assign hit      = rd_vld_r && (rd_data_r == key_r);
  assign sts.is_search = (op_r == bdws_pkg::OP_SEARCH);
  assign sts.srch_end  = hit || (!rd_vld_r && (idx_r == count_r));
  assign step_go  = cmd.srch_step && !sts.srch_end;
  assign rd_issue = step_go && (idx_r != count_r);
  assign rd_addr  = bdws_pkg::ring_add(head_r, idx_r[bdws_pkg::AW-1:0]);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = bdws_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = bdws_pkg::ring_add(head_r, count_r[bdws_pkg::AW-1:0]);
    unique case (op_r)
      bdws_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = bdws_pkg::ST_FULL;
        end else begin
          head_nxt  = bdws_pkg::ring_add(head_r, bdws_pkg::AW'(bdws_pkg::DEPTH - 1));
          wr_addr   = head_nxt;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bdws_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = bdws_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      bdws_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = bdws_pkg::ST_EMPTY;
        end else begin
          head_nxt  = bdws_pkg::ring_add(head_r, bdws_pkg::AW'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      bdws_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_nxt = bdws_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      bdws_pkg::OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= key_r;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else if (step_go) begin
        rd_vld_r <= rd_issue;
        if (rd_issue) begin
          idx_r    <= idx_r + 1'b1;
          rd_pos_r <= idx_r[bdws_pkg::AW-1:0];
        end
      end
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_cmd;
      key_r <= in_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      pos_r    <= '0;
      cnt_r    <= bdws_pkg::CNT_W'(count_nxt);
    end else if (cmd.srch_out) begin
      status_r <= hit ? bdws_pkg::ST_OK : bdws_pkg::ST_NOTFOUND;
      pos_r    <= hit ? bdws_pkg::POS_W'(rd_pos_r) : '0;
      cnt_r    <= bdws_pkg::CNT_W'(count_r);
    end
  end

  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_count    = cnt_r;

  `BDWS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= bdws_pkg::DEPTH_C)
  `BDWS_ASSERT_NOW(a_idx_bound, cmd.srch_step, idx_r <= count_r)
  `BDWS_ASSERT_NEXT(a_push_grows, cmd.exec && wr_en, count_r == $past(count_r) + 1'b1)

endmodule

// ===== hw/rtl/bdws_ctrl.sv =====
`include "bounded_deque_with_search_top_macros.svh"

module bdws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bdws_pkg::ctl_cmd_t cmd,
  input  bdws_pkg::dp_sts_t  sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_search) begin
          state_nxt = S_SEARCH;
        end else if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        // The hit or the exhausted scan is held until the result register frees up.
        if (sts.srch_end && out_free) begin
          cmd.srch_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `BDWS_ASSERT_NOW(a_one_result, 1'b1, !(cmd.exec && cmd.srch_out))
  `BDWS_ASSERT_NOW(a_no_overwrite, cmd.exec || cmd.srch_out, out_free)
  `BDWS_ASSERT_NEXT(a_load_then_exec, cmd.load, state_r == S_EXEC)

endmodule
